// ----- hdl/assert_macros.svh -----
// Assertion macros for the specular lobe block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset
`define PSLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included
`define PSLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hdl/psle_pkg.sv -----
// Package: constants, types and interpolation tables of the specular lobe block
package psle_pkg;

    localparam int SEGS = 64;
    localparam int FB   = 14;

    localparam int SG_W   = $clog2(SEGS + 1);
    localparam int ND_W   = FB + 6;
    localparam int PR_W   = ND_W + 16;
    localparam int RS_W   = PR_W + 2;
    localparam int R_W    = FB + 10;
    localparam int PD_W   = R_W + 16;
    localparam int DS_W   = PD_W + 2;
    localparam int D_W    = FB + 14;
    localparam int P_W    = $clog2(D_W);
    localparam int LSC_W  = 30 + SG_W;
    localparam int NG_W   = 36;
    localparam int NEG_W  = FB + 6;
    localparam int T_W    = NEG_W + 16;
    localparam int IP_W   = T_W - (FB + 8);
    localparam int U_W    = FB + 9;
    localparam int ESC_W  = U_W + SG_W;
    localparam int CS_W   = 32;
    localparam int Q_W    = 63;

    localparam logic [2:0] REG_RED      = 3'd0;
    localparam logic [2:0] REG_GREEN    = 3'd1;
    localparam logic [2:0] REG_BLUE     = 3'd2;
    localparam logic [2:0] REG_STRENGTH = 3'd3;
    localparam logic [2:0] REG_EXPONENT = 3'd4;

    typedef logic [31:0] tab_t [0:SEGS];

    typedef struct packed {
        logic [2:0][CS_W-1:0] cs;
        logic [15:0]          exponent;
    } psle_cfg_t;

    function automatic longint unsigned log2_mant(input longint unsigned xin);
        longint unsigned x;
        longint unsigned res;
        x   = xin;
        res = 0;
        for (int i = 29; i >= 0; i--) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                x   = x >> 1;
                res = res | (64'd1 << i);
            end
        end
        return res;
    endfunction

    function automatic tab_t build_log();
        tab_t t;
        longint unsigned k;
        for (int i = 0; i < SEGS; i++) begin
            k = longint'(i);
            t[i] = 32'(log2_mant((64'd1 << 30) + (k << 30) / SEGS));
        end
        t[SEGS] = 32'd1 << 30;
        for (int i = 1; i <= SEGS; i++) begin
            if (t[i] < t[i-1]) t[i] = t[i-1];
        end
        return t;
    endfunction

    function automatic tab_t build_exp();
        tab_t t;
        longint unsigned k, target, lo, hi, mid;
        t[0] = 32'd1 << 30;
        for (int i = 1; i < SEGS; i++) begin
            k      = longint'(i);
            target = (k << 30) / SEGS;
            lo     = 64'd1 << 30;
            hi     = 64'd1 << 31;
            for (int it = 0; it < 40; it++) begin
                if (lo < hi) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (log2_mant(mid) >= target) hi = mid;
                    else lo = mid + 1;
                end
            end
            t[i] = 32'(lo);
        end
        t[SEGS] = 32'h8000_0000;
        for (int i = 1; i <= SEGS; i++) begin
            if (t[i] < t[i-1]) t[i] = t[i-1];
        end
        return t;
    endfunction

    localparam tab_t LOG_TAB = build_log();
    localparam tab_t EXP_TAB = build_exp();

endpackage

// ----- hdl/psle_cfg.sv -----
// Configuration registers and colour-times-strength products
module psle_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_wdata,
    output psle_pkg::psle_cfg_t  cfg
);

    logic [15:0] red_reg, green_reg, blue_reg, strength_reg, exponent_reg;
    logic [2:0][psle_pkg::CS_W-1:0] cs_reg, cs_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg      <= 16'd4096;
            green_reg    <= 16'd4096;
            blue_reg     <= 16'd4096;
            strength_reg <= 16'd4096;
            exponent_reg <= 16'd2560;
        end else if (cfg_we) begin
            case (cfg_index)
                psle_pkg::REG_RED:      red_reg      <= cfg_wdata;
                psle_pkg::REG_GREEN:    green_reg    <= cfg_wdata;
                psle_pkg::REG_BLUE:     blue_reg     <= cfg_wdata;
                psle_pkg::REG_STRENGTH: strength_reg <= cfg_wdata;
                psle_pkg::REG_EXPONENT: exponent_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cs_next[0] = 32'(red_reg) * 32'(strength_reg);
        cs_next[1] = 32'(green_reg) * 32'(strength_reg);
        cs_next[2] = 32'(blue_reg) * 32'(strength_reg);
    end

    always_ff @(posedge aclk) begin
        cs_reg <= cs_next;
    end

    assign cfg.cs       = cs_reg;
    assign cfg.exponent = exponent_reg;

endmodule

// ----- hdl/phong_specular_lobe_eval.sv -----
// Top level: pipelined Phong specular lobe evaluator
//
// Input channel s_*: one request carries normal, incoming and outgoing
// direction, nine signed Q2.14 words in s_tdata. Output channel m_*: three
// saturated Q4.12 colour words in m_tdata, the hit flag in m_tuser.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (red, green, blue, strength, exponent); write only while idle.
// Sixteen register stages: reflection dot products, normalisation, log2
// table interpolation, exponent multiply, exp2 table interpolation, colour
// scale and saturation. One request is taken per cycle unless a stalled
// receiver has filled the stages, set by the single-issue stage chain.
// Each stage holds its valid bit and advances when the stage after it is
// empty or moving, so a stalled receiver fills bubbles first and then
// drops s_tready; nothing is lost or repeated.
// Reset clears all valid bits and restores register defaults.
module phong_specular_lobe_eval (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // normal_x, normal_y, normal_z, light_dir_x..z, view_dir_x..z
    input  logic [143:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // out_red, out_green, out_blue
    output logic [47:0]   m_tdata,
    // lobe_hit
    output logic [0:0]    m_tuser,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_wdata
);

    `include "assert_macros.svh"

    localparam int NS  = 16;
    localparam int FB  = psle_pkg::FB;
    localparam int SW  = psle_pkg::SG_W;

    psle_pkg::psle_cfg_t cfg;

    psle_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    logic [NS:1] vld_reg;
    logic [NS:1] en;

    always_comb begin
        en[NS] = !vld_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[1]) vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    logic signed [15:0] in_n [3], in_wi [3], in_wo [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_n[i]  = s_tdata[16*i +: 16];
            in_wi[i] = s_tdata[48 + 16*i +: 16];
            in_wo[i] = s_tdata[96 + 16*i +: 16];
        end
    end

    // stage registers
    logic signed [31:0] s1_pn [3];
    logic signed [15:0] s1_n [3], s1_wi [3], s1_wo [3];
    logic signed [psle_pkg::ND_W-1:0] s2_nd;
    logic signed [15:0] s2_n [3], s2_wi [3], s2_wo [3];
    logic signed [psle_pkg::PR_W-1:0] s3_pr [3];
    logic signed [15:0] s3_wi [3], s3_wo [3];
    logic signed [psle_pkg::R_W-1:0] s4_r [3];
    logic signed [15:0] s4_wo [3];
    logic signed [psle_pkg::PD_W-1:0] s5_pd [3];
    logic [psle_pkg::D_W-1:0] s6_d;
    logic s6_hit, s6_sat;
    logic [29:0] s7_frac;
    logic [psle_pkg::P_W-1:0] s7_p;
    logic s7_hit, s7_sat;
    logic [31:0] s8_base, s8_diff;
    logic [29:0] s8_rem;
    logic [psle_pkg::P_W-1:0] s8_p;
    logic s8_hit, s8_sat;
    logic [31:0] s9_base, s9_lgi;
    logic [psle_pkg::P_W-1:0] s9_p;
    logic s9_hit, s9_sat;
    logic [psle_pkg::NEG_W-1:0] s10_neg;
    logic s10_hit, s10_sat;
    logic [psle_pkg::T_W-1:0] s11_t;
    logic s11_hit, s11_sat;
    logic [psle_pkg::IP_W-1:0] s12_ip;
    logic [31:0] s12_base, s12_diff;
    logic [FB+7:0] s12_rem;
    logic s12_hit, s12_sat;
    logic [psle_pkg::IP_W-1:0] s13_ip;
    logic [31:0] s13_base, s13_ef;
    logic s13_hit, s13_sat;
    logic [30:0] s14_lobe;
    logic s14_hit;
    logic [psle_pkg::Q_W-1:0] s15_q [3];
    logic s15_hit;
    logic [47:0] s16_data;
    logic s16_hit;

    // combinational next values
    logic signed [33:0] dot_sum;
    logic signed [psle_pkg::RS_W-1:0] rs [3];
    logic signed [psle_pkg::DS_W-1:0] dsum;
    logic [psle_pkg::P_W-1:0] lead_p;
    logic [FB+43:0] mant_ext;
    logic [psle_pkg::LSC_W-1:0] lsc;
    logic [SW-1:0] lidx;
    logic [61:0] lprod;
    logic [31:0] lg;
    logic [psle_pkg::NG_W-1:0] negw;
    logic [FB+7:0] fp;
    logic [psle_pkg::U_W-1:0] u;
    logic [psle_pkg::ESC_W-1:0] esc;
    logic [SW-1:0] eidx;
    logic [FB+39:0] eprod;
    logic [31:0] v;
    logic [psle_pkg::IP_W:0] sh;
    logic [31:0] shifted;
    logic [30:0] lobe;
    logic [20:0] qhi [3];
    logic [47:0] out_next;

    always_comb begin
        dot_sum = 34'(s1_pn[0]) + 34'(s1_pn[1]) + 34'(s1_pn[2]);
        for (int i = 0; i < 3; i++) begin
            rs[i] = (psle_pkg::RS_W'(s3_pr[i]) <<< 1) - (psle_pkg::RS_W'(s3_wi[i]) <<< FB);
        end
        dsum = psle_pkg::DS_W'(s5_pd[0]) + psle_pkg::DS_W'(s5_pd[1])
             + psle_pkg::DS_W'(s5_pd[2]);

        lead_p = '0;
        for (int b = 0; b < psle_pkg::D_W; b++) begin
            if (s6_d[b]) lead_p = psle_pkg::P_W'(b);
        end
        mant_ext = {s6_d, 30'd0} >> lead_p;

        lsc  = psle_pkg::LSC_W'(s7_frac) * psle_pkg::LSC_W'(psle_pkg::SEGS);
        lidx = lsc[psle_pkg::LSC_W-1 -: SW];

        lprod = 62'(s8_diff) * 62'(s8_rem);

        lg   = s9_base + s9_lgi;
        negw = ((psle_pkg::NG_W'(FB + 14) - psle_pkg::NG_W'(s9_p)) << 30)
             - psle_pkg::NG_W'(lg);

        fp   = s11_t[FB+7:0];
        u    = (psle_pkg::U_W'(1) << (FB + 8)) - psle_pkg::U_W'(fp);
        esc  = psle_pkg::ESC_W'(u) * psle_pkg::ESC_W'(psle_pkg::SEGS);
        eidx = esc[FB+8 +: SW];

        eprod = (FB + 40)'(s12_diff) * (FB + 40)'(s12_rem);

        v       = s13_base + s13_ef;
        sh      = (psle_pkg::IP_W + 1)'(s13_ip) + 1'b1;
        shifted = v >> sh;
        if (s13_sat) lobe = 31'd1 << 30;
        else if (s13_ip >= psle_pkg::IP_W'(31)) lobe = '0;
        else lobe = shifted[30:0];

        for (int i = 0; i < 3; i++) begin
            qhi[i] = s15_q[i][62:42];
            if (!s15_hit) out_next[16*i +: 16] = '0;
            else if (qhi[i] > 21'hFFFF) out_next[16*i +: 16] = 16'hFFFF;
            else out_next[16*i +: 16] = qhi[i][15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                s1_pn[i] <= in_n[i] * in_wi[i];
                s1_n[i]  <= in_n[i];
                s1_wi[i] <= in_wi[i];
                s1_wo[i] <= in_wo[i];
            end
        end
        if (en[2]) begin
            s2_nd <= psle_pkg::ND_W'(dot_sum >>> (28 - FB));
            s2_n  <= s1_n;
            s2_wi <= s1_wi;
            s2_wo <= s1_wo;
        end
        if (en[3]) begin
            for (int i = 0; i < 3; i++) begin
                s3_pr[i] <= psle_pkg::PR_W'(s2_nd) * psle_pkg::PR_W'(s2_n[i]);
            end
            s3_wi <= s2_wi;
            s3_wo <= s2_wo;
        end
        if (en[4]) begin
            for (int i = 0; i < 3; i++) begin
                s4_r[i] <= psle_pkg::R_W'(rs[i] >>> 14);
            end
            s4_wo <= s3_wo;
        end
        if (en[5]) begin
            for (int i = 0; i < 3; i++) begin
                s5_pd[i] <= psle_pkg::PD_W'(s4_r[i]) * psle_pkg::PD_W'(s4_wo[i]);
            end
        end
        if (en[6]) begin
            s6_d   <= dsum[psle_pkg::D_W-1:0];
            s6_hit <= (dsum > 0);
            s6_sat <= (dsum >= (psle_pkg::DS_W'(1) <<< psle_pkg::D_W));
        end
        if (en[7]) begin
            s7_frac <= mant_ext[29:0];
            s7_p    <= lead_p;
            s7_hit  <= s6_hit;
            s7_sat  <= s6_sat;
        end
        if (en[8]) begin
            s8_base <= psle_pkg::LOG_TAB[lidx];
            s8_diff <= psle_pkg::LOG_TAB[SW'(lidx + 1'b1)] - psle_pkg::LOG_TAB[lidx];
            s8_rem  <= lsc[29:0];
            s8_p    <= s7_p;
            s8_hit  <= s7_hit;
            s8_sat  <= s7_sat;
        end
        if (en[9]) begin
            s9_base <= s8_base;
            s9_lgi  <= lprod[61:30];
            s9_p    <= s8_p;
            s9_hit  <= s8_hit;
            s9_sat  <= s8_sat;
        end
        if (en[10]) begin
            s10_neg <= psle_pkg::NEG_W'(negw >> (30 - FB));
            s10_hit <= s9_hit;
            s10_sat <= s9_sat;
        end
        if (en[11]) begin
            s11_t   <= psle_pkg::T_W'(s10_neg) * psle_pkg::T_W'(cfg.exponent);
            s11_hit <= s10_hit;
            s11_sat <= s10_sat;
        end
        if (en[12]) begin
            s12_ip <= s11_t[psle_pkg::T_W-1:FB+8];
            if (eidx >= SW'(psle_pkg::SEGS)) begin
                s12_base <= psle_pkg::EXP_TAB[psle_pkg::SEGS];
                s12_diff <= '0;
            end else begin
                s12_base <= psle_pkg::EXP_TAB[eidx];
                s12_diff <= psle_pkg::EXP_TAB[SW'(eidx + 1'b1)] - psle_pkg::EXP_TAB[eidx];
            end
            s12_rem <= esc[FB+7:0];
            s12_hit <= s11_hit;
            s12_sat <= s11_sat;
        end
        if (en[13]) begin
            s13_ip   <= s12_ip;
            s13_base <= s12_base;
            s13_ef   <= eprod[FB+39:FB+8];
            s13_hit  <= s12_hit;
            s13_sat  <= s12_sat;
        end
        if (en[14]) begin
            s14_lobe <= lobe;
            s14_hit  <= s13_hit;
        end
        if (en[15]) begin
            for (int i = 0; i < 3; i++) begin
                s15_q[i] <= psle_pkg::Q_W'(cfg.cs[i]) * psle_pkg::Q_W'(s14_lobe);
            end
            s15_hit <= s14_hit;
        end
        if (en[16]) begin
            s16_data <= out_next;
            s16_hit  <= s15_hit;
        end
    end

    assign m_tvalid   = vld_reg[NS];
    assign m_tdata    = s16_data;
    assign m_tuser[0] = s16_hit;

    `PSLE_ASSERT(a_miss_black, (m_tvalid && !m_tuser[0]) |-> (m_tdata == 48'd0), "miss not black")
    `PSLE_ASSERT(a_full_stall, !s_tready |-> (m_tvalid && !m_tready), "stall while not full")
    `PSLE_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "valid after reset")

endmodule

// ----- dv/tb.sv -----
// Testbench for the Phong specular lobe evaluator: streamed requests checked against a local predictor
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic [15:0] v [9];
    } shade_req_t;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        hit;
    } shade_res_t;

    typedef struct {
        logic [15:0] v [9];
        bit          known;
        shade_res_t  res;
    } shade_row_t;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    logic [143:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [47:0]   m_tdata;
    logic [0:0]    m_tuser;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [15:0]   cfg_wdata;

    phong_specular_lobe_eval uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    longint unsigned log_seg [0:64];
    longint unsigned exp_seg [0:64];
    logic [15:0]     shade_cfg [5];
    shade_res_t      lobe_q [$];
    bit              known_q [$];
    shade_res_t      typed_q [$];
    int              fails = 0;
    int              n_hits = 0;
    int              n_results = 0;
    int              stall_mode = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint unsigned mant_log2(longint unsigned xin);
        longint unsigned x, acc;
        x = xin;
        acc = 0;
        for (int i = 29; i >= 0; i--) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                acc |= 64'd1 << i;
            end
        end
        return acc;
    endfunction

    task automatic fill_segments();
        longint unsigned goal, lo, hi, mid;
        for (int k = 0; k < 64; k++)
            log_seg[k] = mant_log2((64'd1 << 30) + ((64'(k)) << 30) / 64);
        log_seg[64] = 64'd1 << 30;
        exp_seg[0] = 64'd1 << 30;
        for (int k = 1; k < 64; k++) begin
            goal = ((64'(k)) << 30) / 64;
            lo = 64'd1 << 30;
            hi = 64'd1 << 31;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (mant_log2(mid) >= goal) hi = mid;
                else lo = mid + 1;
            end
            exp_seg[k] = lo;
        end
        exp_seg[64] = 64'd1 << 31;
        for (int k = 1; k <= 64; k++) begin
            if (log_seg[k] < log_seg[k-1]) log_seg[k] = log_seg[k-1];
            if (exp_seg[k] < exp_seg[k-1]) exp_seg[k] = exp_seg[k-1];
        end
    endtask

    function automatic longint unsigned lobe_power(longint unsigned dr);
        longint unsigned mant, frac, sc, idx, rem, lg, neg, t, ip, fp, u, v;
        longint unsigned tmask;
        int p;
        tmask = (64'd1 << 22) - 1;
        if (dr >= (64'd1 << 28)) return 64'd1 << 30;
        p = 0;
        while ((dr >> (p + 1)) != 0) p++;
        mant = dr << (30 - p);
        frac = mant - (64'd1 << 30);
        sc = frac * 64;
        idx = sc >> 30;
        rem = sc & ((64'd1 << 30) - 1);
        lg = log_seg[idx] + (((log_seg[idx+1] - log_seg[idx]) * rem) >> 30);
        neg = (64'(28 - p) << 30) - lg;
        neg = neg >> 16;
        t = neg * 64'(shade_cfg[psle_pkg::REG_EXPONENT]);
        ip = t >> 22;
        fp = t & tmask;
        u = (tmask + 1) - fp;
        sc = u * 64;
        idx = sc >> 22;
        rem = sc & tmask;
        if (idx >= 64) v = exp_seg[64];
        else v = exp_seg[idx] + (((exp_seg[idx+1] - exp_seg[idx]) * rem) >> 22);
        if (ip >= 62) return 0;
        return v >> (ip + 1);
    endfunction

    function automatic shade_res_t predict_shade(logic [143:0] d);
        longint n [3], wi [3], wo [3], r [3];
        longint dot, nd, dr;
        longint unsigned lobe, q;
        logic [15:0] ch [3];
        shade_res_t o;
        for (int i = 0; i < 3; i++) begin
            n[i]  = longint'($signed(d[16*i +: 16]));
            wi[i] = longint'($signed(d[16*(i+3) +: 16]));
            wo[i] = longint'($signed(d[16*(i+6) +: 16]));
        end
        dot = n[0] * wi[0] + n[1] * wi[1] + n[2] * wi[2];
        nd = dot >>> 14;
        for (int i = 0; i < 3; i++)
            r[i] = (-wi[i] * 16384 + 2 * nd * n[i]) >>> 14;
        dr = r[0] * wo[0] + r[1] * wo[1] + r[2] * wo[2];
        if (dr <= 0) begin
            o = '{16'd0, 16'd0, 16'd0, 1'b0};
            return o;
        end
        lobe = lobe_power(64'(dr));
        for (int i = 0; i < 3; i++) begin
            q = ((64'(shade_cfg[i]) * 64'(shade_cfg[psle_pkg::REG_STRENGTH])) * lobe) >> 42;
            ch[i] = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
        end
        o = '{ch[0], ch[1], ch[2], 1'b1};
        return o;
    endfunction

    function automatic logic [143:0] pack_req(logic [15:0] v [9]);
        logic [143:0] d;
        for (int i = 0; i < 9; i++) d[16*i +: 16] = v[i];
        return d;
    endfunction

    // predict on every accepted request, check every accepted result
    always @(posedge aclk) begin
        shade_res_t e;
        bit k;
        if (aresetn && s_tvalid && s_tready) begin
            e = predict_shade(s_tdata);
            k = known_q.pop_front();
            if (k) e = typed_q.pop_front();
            lobe_q.push_back(e);
        end
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (m_tuser[0]) n_hits++;
            if (lobe_q.size() == 0) begin
                $error("result with no request outstanding");
                fails++;
            end else begin
                e = lobe_q.pop_front();
                if (m_tdata[15:0] !== e.red) begin
                    $error("out_red expected %0d got %0d", e.red, m_tdata[15:0]);
                    fails++;
                end
                if (m_tdata[31:16] !== e.green) begin
                    $error("out_green expected %0d got %0d", e.green, m_tdata[31:16]);
                    fails++;
                end
                if (m_tdata[47:32] !== e.blue) begin
                    $error("out_blue expected %0d got %0d", e.blue, m_tdata[47:32]);
                    fails++;
                end
                if (m_tuser[0] !== e.hit) begin
                    $error("lobe_hit expected %0d got %0d", e.hit, m_tuser[0]);
                    fails++;
                end
            end
        end
    end

    // receiver back-pressure: the stall pattern is redrawn at random among four modes
    always @(posedge aclk) begin
        if (($urandom & 255) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_req(logic [15:0] v [9], bit known, shade_res_t res);
        known_q.push_back(known);
        if (known) typed_q.push_back(res);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_req(v);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (lobe_q.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx <= psle_pkg::REG_EXPONENT) shade_cfg[idx] = val;
        @(posedge aclk);
    endtask

    task automatic set_cfg(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic [15:0] ks, logic [15:0] ex);
        write_cfg(psle_pkg::REG_RED, r);
        write_cfg(psle_pkg::REG_GREEN, g);
        write_cfg(psle_pkg::REG_BLUE, b);
        write_cfg(psle_pkg::REG_STRENGTH, ks);
        write_cfg(psle_pkg::REG_EXPONENT, ex);
        write_cfg(3'd7, 16'h0000);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic void rand_req(output logic [15:0] v [9]);
        int kind;
        int a, b, c;
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
            for (int i = 0; i < 9; i++) v[i] = 16'($urandom);
        end else if (kind < 5) begin
            for (int i = 0; i < 9; i++) v[i] = 16'($urandom_range(0, 32768) - 16384);
        end else begin
            // near-mirror geometry on an axis normal, with a jittered view
            a = $urandom_range(0, 23170) - 11585;
            b = $urandom_range(0, 23170) - 11585;
            c = $urandom_range(0, 16384);
            for (int i = 0; i < 3; i++) v[i] = 16'd0;
            v[2] = 16'd16384;
            v[3] = 16'(a); v[4] = 16'(b); v[5] = 16'(c);
            v[6] = 16'(-a + $urandom_range(0, 2 * kind) - kind);
            v[7] = 16'(-b + $urandom_range(0, 2 * kind) - kind);
            v[8] = 16'(c + $urandom_range(0, 2 * kind) - kind);
        end
    endfunction

    task automatic random_run(int count);
        logic [15:0] v [9];
        shade_res_t none;
        int burst;
        none = '{16'd0, 16'd0, 16'd0, 1'b0};
        while (count > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && count > 0) begin
                rand_req(v);
                send_req(v, 1'b0, none);
                burst--;
                count--;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    endtask

    shade_row_t dir_rows [] = '{
        '{'{16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd16384},
          1'b1, '{16'd4096, 16'd4096, 16'd4096, 1'b1}},
        '{'{16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'hC000},
          1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
          1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000, 16'h8000, 16'h8000}, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
            16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
            16'h7FFF, 16'h8000, 16'h7FFF}, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{'{16'd0, 16'd0, 16'd16384, 16'd11585, 16'd0, 16'd11585,
            16'hD2BF, 16'd0, 16'd11585}, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{'{16'd0, 16'd0, 16'd16384, 16'd11585, 16'd0, 16'd11585,
            16'hD2C9, 16'd100, 16'd11500}, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{'{16'd0, 16'd0, 16'd16384, 16'd11585, 16'd0, 16'd11585,
            16'd0, 16'd0, 16'd1}, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{'{16'd0, 16'd16384, 16'd0, 16'd0, 16'd8192, 16'd14189,
            16'd0, 16'd8192, 16'hC8A3}, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{'{16'd0, 16'd16384, 16'd0, 16'd0, 16'd8192, 16'd14189,
            16'd0, 16'd8192, 16'd14189}, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{'{16'd8192, 16'd8192, 16'd8192, 16'd1, 16'd1, 16'd1,
            16'd1, 16'd1, 16'd1}, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}}
    };

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = psle_pkg::REG_RED;
        cfg_wdata = '0;
        shade_cfg = '{16'd4096, 16'd4096, 16'd4096, 16'd4096, 16'd2560};
        fill_segments();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_req(dir_rows[i].v, dir_rows[i].known, dir_rows[i].res);
        drain();

        // zero exponent: a tiny dot product still gives a full lobe
        set_cfg(16'd4096, 16'd2048, 16'd1, 16'd4096, 16'd0);
        for (int i = 6; i < dir_rows.size(); i++)
            send_req(dir_rows[i].v, 1'b0, dir_rows[i].res);
        drain();

        random_run(300);
        drain();
        set_cfg(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_run(300);
        drain();
        set_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd256);
        random_run(300);
        drain();
        set_cfg(16'h0000, 16'd4096, 16'd12000, 16'd1, 16'd1);
        random_run(250);
        drain();
        set_cfg(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom_range(1, 4096)));
        random_run(300);
        drain();
        set_cfg(16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom_range(2048, 8192)), 16'($urandom));
        random_run(300);
        drain();

        $display("Covered %0d results (%0d hits) over seven register settings,",
                 n_results, n_hits);
        $display("with zero and full-scale exponents, colours and strength.");
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
